[hw/rtl/sfbp_pkg.sv]
// Shared types and constants for the sync frame block parser.
`timescale 1ns / 1ps

package sfbp_pkg;

    localparam int PAYLOAD_BYTES = 14;
    localparam int FRAME_BYTES   = PAYLOAD_BYTES + 2;
    localparam int POS_W         = $clog2(FRAME_BYTES);
    localparam int PAYLOAD_START = 2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SYNC_FIRST  = 2'd0,
        CFG_SYNC_SECOND = 2'd1,
        CFG_RESP_TYPE   = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [7:0] sync_first;
        logic [7:0] sync_second;
        logic [7:0] resp_type;
    } t_cfg;

    typedef struct packed {
        logic [15:0]        signature;
        logic [15:0]        x_pos;
        logic [15:0]        y_pos;
        logic [15:0]        blk_width;
        logic [15:0]        blk_height;
        logic signed [15:0] angle;
        logic [7:0]         track_index;
        logic [7:0]         track_age;
        logic               checksum_ok;
    } t_result;

endpackage

[hw/rtl/sfbp_core.sv]
// Header window, frame capture and running checksum for one byte per step.
`timescale 1ns / 1ps

module sfbp_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic [7:0]       i_byte,
    input  sfbp_pkg::t_cfg   i_cfg,
    output logic             o_emit,
    output sfbp_pkg::t_result o_result
);

    localparam int                     LAST_IDX = sfbp_pkg::FRAME_BYTES - 1;
    localparam logic [sfbp_pkg::POS_W-1:0] LAST_POS = LAST_IDX[sfbp_pkg::POS_W-1:0];
    localparam logic [sfbp_pkg::POS_W-1:0] PAY_POS  =
        sfbp_pkg::PAYLOAD_START[sfbp_pkg::POS_W-1:0];
    localparam logic [7:0] HDR_LEN = sfbp_pkg::PAYLOAD_BYTES[7:0];

    logic [7:0]                 r_hist [3];
    logic                       r_capturing, n_capturing;
    logic [sfbp_pkg::POS_W-1:0] r_count, n_count;
    logic [15:0]                r_sum, n_sum;
    logic [7:0]                 r_frame [LAST_IDX];

    logic        w_header;
    logic        w_last;
    logic [15:0] w_total;

    assign w_header = (r_hist[2] == i_cfg.sync_first) && (r_hist[1] == i_cfg.sync_second)
                   && (r_hist[0] == i_cfg.resp_type) && (i_byte == HDR_LEN);
    assign w_last   = r_capturing && (r_count == LAST_POS);
    assign w_total  = r_sum + {8'd0, i_byte};

    always_comb begin
        n_capturing = r_capturing;
        n_count     = r_count;
        n_sum       = r_sum;
        if (r_capturing) begin
            n_sum = (r_count < PAY_POS) ? 16'd0 : w_total;
            if (w_last) begin
                n_capturing = 1'b0;
                n_count     = '0;
            end else begin
                n_count = r_count + 1'b1;
            end
        end
        if (w_header) begin
            n_capturing = 1'b1;
            n_count     = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist      <= '{default: 8'd0};
            r_capturing <= 1'b0;
            r_count     <= '0;
            r_sum       <= 16'd0;
        end else if (i_step) begin
            r_hist[2]   <= r_hist[1];
            r_hist[1]   <= r_hist[0];
            r_hist[0]   <= i_byte;
            r_capturing <= n_capturing;
            r_count     <= n_count;
            r_sum       <= n_sum;
        end
    end

    // Final byte goes straight to the result; earlier bytes are stored.
    always_ff @(posedge i_clk) begin
        if (i_step && r_capturing && !w_last) begin
            r_frame[r_count] <= i_byte;
        end
    end

    assign o_emit = w_last;

    always_comb begin
        o_result.signature   = {r_frame[3], r_frame[2]};
        o_result.x_pos       = {r_frame[5], r_frame[4]};
        o_result.y_pos       = {r_frame[7], r_frame[6]};
        o_result.blk_width   = {r_frame[9], r_frame[8]};
        o_result.blk_height  = {r_frame[11], r_frame[10]};
        o_result.angle       = {r_frame[13], r_frame[12]};
        o_result.track_index = r_frame[14];
        o_result.track_age   = i_byte;
        o_result.checksum_ok = (w_total == {r_frame[1], r_frame[0]});
    end

endmodule

[hw/rtl/sync_frame_block_parser.sv]
// Top level of the sync frame block parser: handshakes, configuration, result register.
`timescale 1ns / 1ps

// Takes one received byte per item and accepts a byte every cycle unless
// a result waits unread in the output register. A byte is held in the input
// register, where the header window compare, frame store write and running
// payload sum happen, and its result, if any, is registered into the output
// register once the output register can advance. A result is produced on the
// 16th byte after a header
// (sync first, sync second, response type, payload length 14) and carries
// checksum_ok = 0 on a mismatch. A new header restarts capture at once.
// Configuration writes take effect at the next edge; write only while idle.

module sync_frame_block_parser (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [sfbp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [sfbp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [7:0]                     i_rx_byte,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [15:0]                    o_signature,
    output logic [15:0]                    o_x_pos,
    output logic [15:0]                    o_y_pos,
    output logic [15:0]                    o_blk_width,
    output logic [15:0]                    o_blk_height,
    output logic signed [15:0]             o_angle,
    output logic [7:0]                     o_track_index,
    output logic [7:0]                     o_track_age,
    output logic                           o_checksum_ok
);

    sfbp_pkg::t_cfg    r_cfg;
    logic              r_in_valid;
    logic [7:0]        r_in_byte;
    logic              r_out_valid;
    sfbp_pkg::t_result r_out;

    logic              w_advance;
    logic              w_step;
    logic              w_emit;
    sfbp_pkg::t_result w_result;

    assign w_advance  = !r_out_valid || i_out_ready;
    assign w_step     = r_in_valid && w_advance;
    assign o_in_ready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_first  <= 8'd175;
            r_cfg.sync_second <= 8'd193;
            r_cfg.resp_type   <= 8'd33;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                sfbp_pkg::CFG_SYNC_FIRST:  r_cfg.sync_first  <= i_cfg_data;
                sfbp_pkg::CFG_SYNC_SECOND: r_cfg.sync_second <= i_cfg_data;
                sfbp_pkg::CFG_RESP_TYPE:   r_cfg.resp_type   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Hold the item until the core can advance.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_rx_byte;
        end
    end

    sfbp_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_byte   (r_in_byte),
        .i_cfg    (r_cfg),
        .o_emit   (w_emit),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= w_step && w_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step && w_emit) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_signature   = r_out.signature;
    assign o_x_pos       = r_out.x_pos;
    assign o_y_pos       = r_out.y_pos;
    assign o_blk_width   = r_out.blk_width;
    assign o_blk_height  = r_out.blk_height;
    assign o_angle       = r_out.angle;
    assign o_track_index = r_out.track_index;
    assign o_track_age   = r_out.track_age;
    assign o_checksum_ok = r_out.checksum_ok;

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_in_valid && r_out_valid && !i_out_ready))
        else $error("input stalled without a blocked result");

    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && !(w_step && w_emit)) |=> !o_out_valid)
        else $error("result valid without a completed frame");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(r_out)))
        else $error("pending result changed or dropped");

    a_emit_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && w_advance && !r_in_valid) |=> !o_out_valid)
        else $error("result emitted without an item");

endmodule
